// ===== rtl/centered_moving_average_assert.svh =====
// Assertion macros used by the checker file of the centered moving average.
// Depends on nothing; each user must provide clk and rst_n in scope.
`ifndef CENTERED_MOVING_AVERAGE_ASSERT_SVH
`define CENTERED_MOVING_AVERAGE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define CMA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("centered_moving_average: same-cycle check failed");

// Next-cycle implication, disabled while reset is held
`define CMA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("centered_moving_average: next-cycle check failed");

`endif

// ===== rtl/cma_pkg.sv =====
// Shared types and constants of the centered moving average block.
// No dependencies; used by the top level and the bench.
`default_nettype none

package cma_pkg;

  // Width and reset value of the radius configuration register
  localparam int RADIUS_BITS = 6;
  localparam int RADIUS_RESET = 1;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_UPDATE = 5'b00010,
    ST_DIV    = 5'b00100,
    ST_EMIT   = 5'b01000,
    ST_TRAIL  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/centered_moving_average.sv =====
// Top level of the centered moving average filter: sequencer, running sum,
// bit-serial divider and output register. Uses cma_pkg and cma_ram.
//
// channel | direction | handshake            | payload
// --------+-----------+----------------------+------------------------------------
// cfg     | in        | cfg_valid/cfg_ready  | cfg_data = radius
// in      | in        | in_tvalid/in_tready  | in_tdata = sample, in_tlast = last
// out     | out       | out_tvalid/out_tready| out_tdata = average, out_tlast = eos
//
// When a sample yields a mean, the restoring divider works it out one quotient
// bit a cycle; -1 results and trailing results go straight to the output
// register while the output is free.
// A stalled output holds the sequencer in its emit states; in_tready is low
// until the sequencer returns to idle. Synchronous active-low reset, no
// clearing pass: ring entries are only read after being written.
`default_nettype none

module centered_moving_average
  import cma_pkg::*;
#(
  parameter int MAX_RADIUS = 63,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // radius write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [RADIUS_BITS-1:0]                 cfg_data,
  // sample stream
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       in_tdata,   // [SAMPLE_BITS-1:0] sample
  input  logic                                   in_tlast,
  // result stream
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((SAMPLE_BITS+8)/8)*8-1:0]       out_tdata,  // [SAMPLE_BITS:0] average
  output logic                                   out_tlast
);

  localparam int DEPTH = 2 * MAX_RADIUS + 1;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int POS_W = $clog2(DEPTH + 1);
  localparam int RAD_W = $clog2(MAX_RADIUS + 1);
  localparam int SUM_W = SAMPLE_BITS + PTR_W;
  localparam int CNT_W = $clog2(SUM_W + 1);
  localparam int REM_W = POS_W + 1;
  localparam int AVG_W = SAMPLE_BITS + 1;
  localparam int OUT_W = ((SAMPLE_BITS + 8) / 8) * 8;
  localparam logic [AVG_W-1:0] AVG_ONES = '1;

  // Control registers
  state_t             state_r, state_nxt;
  logic [RAD_W-1:0]   radius_r, radius_nxt;
  logic [POS_W-1:0]   win_r, win_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [PTR_W-1:0]   wp_r, wp_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [RAD_W-1:0]   trail_r, trail_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Payload registers
  logic [SAMPLE_BITS-1:0] smp_r, smp_nxt;
  logic                   last_r, last_nxt;
  logic                   sub_r, sub_nxt;
  logic [SUM_W-1:0]       quo_r, quo_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic [AVG_W-1:0]       res_r, res_nxt;
  logic                   res_eos_r, res_eos_nxt;
  logic [AVG_W-1:0]       out_avg_r, out_avg_nxt;
  logic                   out_eos_r, out_eos_nxt;

  // Ring port signals
  logic                   ram_wr_en;
  logic                   ram_rd_en;
  logic [PTR_W-1:0]       ram_rd_addr;
  logic [SAMPLE_BITS-1:0] ram_rd_data;

  // Datapath helpers
  logic                   in_fire;
  logic                   cfg_fire;
  logic                   out_free;
  logic [POS_W-1:0]       r_ext;
  logic                   has_reg;
  logic                   is_avg;
  logic [SUM_W-1:0]       sum_upd;
  logic [SUM_W-1:0]       sub_val;
  logic [REM_W-1:0]       rem_shift;
  logic                   rem_ge;
  logic [SUM_W-1:0]       quo_shift;
  logic [RAD_W-1:0]       cfg_radius;

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_tready = (state_r == ST_IDLE) && !cfg_valid;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Saturate the written radius to MAX_RADIUS
  assign cfg_radius = (int'(cfg_data) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(cfg_data);

  // Old sample address: write pointer minus window length, modulo ring depth
  always_comb begin
    if (PTR_W'(wp_r) >= PTR_W'(win_r)) begin
      ram_rd_addr = wp_r - PTR_W'(win_r);
    end else begin
      ram_rd_addr = PTR_W'(int'(wp_r) + DEPTH - int'(win_r));
    end
  end
  assign ram_rd_en = in_fire && (pos_r >= win_r);
  assign ram_wr_en = (state_r == ST_UPDATE);

  // Running sum update and position classification
  assign r_ext   = POS_W'(radius_r);
  assign has_reg = pos_r >= r_ext;
  assign is_avg  = pos_r >= (r_ext << 1);
  assign sub_val = sub_r ? SUM_W'(ram_rd_data) : '0;
  assign sum_upd = sum_r - sub_val + SUM_W'(smp_r);

  // One step of the restoring divider
  assign rem_shift = {rem_r[REM_W-2:0], quo_r[SUM_W-1]};
  assign rem_ge    = rem_shift >= REM_W'(win_r);
  assign quo_shift = {quo_r[SUM_W-2:0], rem_ge};

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    radius_nxt    = radius_r;
    win_nxt       = win_r;
    pos_nxt       = pos_r;
    wp_nxt        = wp_r;
    sum_nxt       = sum_r;
    trail_nxt     = trail_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    smp_nxt       = smp_r;
    last_nxt      = last_r;
    sub_nxt       = sub_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    res_nxt       = res_r;
    res_eos_nxt   = res_eos_r;
    out_avg_nxt   = out_avg_r;
    out_eos_nxt   = out_eos_r;

    // Drop the output once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (cfg_fire) begin
          radius_nxt = cfg_radius;
          win_nxt    = POS_W'({cfg_radius, 1'b1});
          pos_nxt    = '0;
          wp_nxt     = '0;
          sum_nxt    = '0;
        end else if (in_fire) begin
          smp_nxt   = in_tdata[SAMPLE_BITS-1:0];
          last_nxt  = in_tlast;
          sub_nxt   = pos_r >= win_r;
          state_nxt = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        // Advance the sum, pointer and position, or restart on the last sample
        if (last_r) begin
          sum_nxt = '0;
          wp_nxt  = '0;
          pos_nxt = '0;
        end else begin
          sum_nxt = sum_upd;
          wp_nxt  = (int'(wp_r) == DEPTH - 1) ? '0 : wp_r + 1'b1;
          pos_nxt = (pos_r >= win_r) ? win_r : pos_r + 1'b1;
        end
        if (last_r) begin
          trail_nxt = has_reg ? radius_r : RAD_W'(pos_r + 1'b1);
        end else begin
          trail_nxt = '0;
        end
        quo_nxt = sum_upd;
        rem_nxt = '0;
        cnt_nxt = CNT_W'(SUM_W);
        if (is_avg) begin
          state_nxt = ST_DIV;
        end else if (has_reg) begin
          res_nxt     = AVG_ONES;
          res_eos_nxt = 1'b0;
          state_nxt   = ST_EMIT;
        end else if (last_r) begin
          state_nxt = ST_TRAIL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_DIV: begin
        rem_nxt = rem_ge ? rem_shift - REM_W'(win_r) : rem_shift;
        quo_nxt = quo_shift;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          res_nxt     = {1'b0, quo_shift[SAMPLE_BITS-1:0]};
          res_eos_nxt = last_r && (trail_r == '0);
          state_nxt   = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = res_r;
          out_eos_nxt   = res_eos_r;
          state_nxt     = (trail_r != '0) ? ST_TRAIL : ST_IDLE;
        end
      end

      ST_TRAIL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = AVG_ONES;
          out_eos_nxt   = (trail_r == RAD_W'(1));
          trail_nxt     = trail_r - 1'b1;
          if (trail_r == RAD_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radius_r    <= RAD_W'(RADIUS_RESET);
      win_r       <= POS_W'(2 * RADIUS_RESET + 1);
      pos_r       <= '0;
      wp_r        <= '0;
      sum_r       <= '0;
      trail_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      radius_r    <= radius_nxt;
      win_r       <= win_nxt;
      pos_r       <= pos_nxt;
      wp_r        <= wp_nxt;
      sum_r       <= sum_nxt;
      trail_r     <= trail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload without reset
  always_ff @(posedge clk) begin
    smp_r     <= smp_nxt;
    last_r    <= last_nxt;
    sub_r     <= sub_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    res_r     <= res_nxt;
    res_eos_r <= res_eos_nxt;
    out_avg_r <= out_avg_nxt;
    out_eos_r <= out_eos_nxt;
  end

  // Sample ring
  cma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH),
    .ADDR_W(PTR_W)
  ) u_ring (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(wp_r),
    .wr_data(smp_r),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_avg_r);
  assign out_tlast  = out_eos_r;

endmodule

`default_nettype wire

// ===== rtl/cma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the sample ring of the moving average.
`default_nettype none

module cma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 127,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cma_check.sv =====
// Port-level checker for the centered moving average, bound to the top level.
// Depends on the macros in centered_moving_average_assert.svh.
`default_nettype none

`include "centered_moving_average_assert.svh"

module cma_check #(
  parameter int SAMPLE_BITS = 16
) (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             cfg_valid,
  input wire logic                             cfg_ready,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [((SAMPLE_BITS+8)/8)*8-1:0] out_tdata,
  input wire logic                             out_tlast
);

  localparam int AVG_W = SAMPLE_BITS + 1;
  localparam logic [AVG_W-1:0] AVG_ONES = '1;

  logic avg_ok;

  // A result is a sample-range mean or the not-fit marker, with zero padding
  assign avg_ok = ((out_tdata[AVG_W-1] == 1'b0) || (out_tdata[AVG_W-1:0] == AVG_ONES)) &&
                  ((out_tdata >> AVG_W) == '0);

  // Hold a stalled result
  `CMA_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable({out_tdata, out_tlast}))

  // A radius write and a sample never share a cycle
  `CMA_ASSERT_IMP(a_cfg_excl, cfg_valid && cfg_ready, !(in_tvalid && in_tready))

  // The block is busy right after taking a sample
  `CMA_ASSERT_NXT(a_busy_after_in, in_tvalid && in_tready, !in_tready && !cfg_ready)

  // Check the result range
  `CMA_ASSERT_IMP(a_avg_range, out_tvalid, avg_ok)

endmodule

bind centered_moving_average cma_check #(.SAMPLE_BITS(SAMPLE_BITS)) u_cma_check (.*);

`default_nettype wire

// ===== bench/centered_moving_average_test.sv =====
// Self-checking bench for centered_moving_average: drives sample sequences and radius writes,
// predicts every window mean and checks each result in order. Depends on cma_pkg and the RTL.
module centered_moving_average_test;
  import cma_pkg::*;

  localparam int RING_DEPTH = 127;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam logic [16:0] NO_MEAN = '1;

  typedef struct packed {
    logic [16:0] average;
    logic        end_of_sequence;
  } window_mean_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [RADIUS_BITS-1:0] cfg_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [15:0]            in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [23:0]            out_tdata;
  logic                   out_tlast;

  // Predictor state: ring of recent samples, running window sum, position in sequence
  logic [15:0]            sample_ring [RING_DEPTH];
  logic [6:0]             wr_ptr = '0;
  logic [22:0]            win_sum = '0;
  logic [7:0]             pos_count = '0;
  logic [RADIUS_BITS-1:0] cur_radius = RADIUS_BITS'(RADIUS_RESET);
  window_mean_t           expected_means [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_granted = 0;
  int hold_left = 0;
  int error_count = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int radius_writes = 0;
  int quiet_cycles = 0;

  centered_moving_average i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [15:0] sample
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [16:0] average, [23:17] zero fill
    .out_tlast (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Clear the running window, as at the end of a sequence or on a radius write
  task automatic restart_window();
    wr_ptr = '0;
    win_sum = '0;
    pos_count = '0;
  endtask

  // Append one expected mean behind the ones already waiting
  task automatic enqueue_mean(input window_mean_t m);
    expected_means.insert(expected_means.size(), m);
  endtask

  // Advance the window by one sample and queue the means it releases
  task automatic predict_window_means(input logic [15:0] smp, input logic last);
    int r;
    int w;
    int p;
    int trail;
    window_mean_t res;
    r = int'(cur_radius);
    w = 2 * r + 1;
    p = int'(pos_count);
    if (p >= w)
      win_sum = win_sum - 23'(sample_ring[(int'(wr_ptr) + RING_DEPTH - w) % RING_DEPTH]);
    sample_ring[wr_ptr] = smp;
    wr_ptr = 7'((int'(wr_ptr) + 1) % RING_DEPTH);
    win_sum = win_sum + 23'(smp);
    if (p >= r) begin
      res.average = (p >= 2 * r) ? 17'(win_sum / 23'(w)) : NO_MEAN;
      res.end_of_sequence = 1'b0;
      enqueue_mean(res);
    end
    pos_count = 8'((p + 1 > w) ? w : p + 1);
    // Last sample: flush the positions whose window runs past the end
    if (last) begin
      trail = (p >= r) ? r : p + 1;
      res.average = NO_MEAN;
      res.end_of_sequence = 1'b0;
      repeat (trail) enqueue_mean(res);
      expected_means[expected_means.size() - 1].end_of_sequence = 1'b1;
      restart_window();
    end
    samples_sent++;
  endtask

  // Offer one sample after a random gap and hold it until the transaction completes
  task automatic send_sample(input logic [15:0] smp, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= smp;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    predict_window_means(smp, last);
    @(negedge clk);
  endtask

  // Drain all results, let the block settle, then write the radius
  task automatic write_radius(input logic [RADIUS_BITS-1:0] r);
    in_tvalid <= 1'b0;
    while (expected_means.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= r;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_radius = r;
    restart_window();
    radius_writes++;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Reset radius of one: full-scale window, a lone sample, a short sequence
  task automatic test_default_radius();
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'd12345, 1'b1);
    send_sample(16'd7, 1'b0);
    send_sample(16'd9, 1'b1);
  endtask

  // Radius zero passes samples through, radius 63 with a too short sequence
  task automatic test_radius_extremes();
    write_radius(6'd0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hA5A5, 1'b1);
    send_sample(16'hFFFF, 1'b1);
    write_radius(6'd63);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h5A5A, 1'b1);
  endtask

  // A radius write in mid-sequence drops the open sequence without a trailing flush
  task automatic test_radius_cuts_sequence();
    write_radius(6'd2);
    send_sample(16'd100, 1'b0);
    send_sample(16'd200, 1'b0);
    send_sample(16'd300, 1'b0);
    write_radius(6'd3);
    for (int k = 0; k < 8; k++) send_sample(pick_sample(), k == 7);
  endtask

  // Random radii and random sequences, mostly small windows
  task automatic test_random_sequences(input int send_pct, input int recv_pct, input int budget);
    int sent;
    int r;
    int len;
    sent = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (sent < budget) begin
      r = ($urandom_range(3) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
      write_radius(RADIUS_BITS'(r));
      repeat ($urandom_range(1, 3)) begin
        len = $urandom_range(1, 2 * r + 8);
        // Most sequences close with a last sample; the rest run on or get cut
        for (int k = 0; k < len; k++)
          send_sample(pick_sample(), (k == len - 1) && ($urandom_range(4) != 0));
        sent += len;
      end
    end
  endtask

  // Largest window at full scale, then the longest trailing flush
  task automatic test_max_radius();
    write_radius(6'd63);
    for (int k = 0; k < 130; k++)
      send_sample((k < RING_DEPTH) ? 16'hFFFF : pick_sample(), k == 129);
  endtask

  // Hold the output off for a long stretch while samples keep coming
  task automatic test_output_backpressure();
    write_radius(6'd1);
    hold_requests++;
    for (int k = 0; k < 20; k++) send_sample(pick_sample(), k == 19);
  endtask

  // Receiver: random ready, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != hold_granted) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_OFF_CYCLES - 1;
      hold_granted <= hold_granted + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result transaction with the oldest expected mean
  always @(posedge clk) begin
    window_mean_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_means.size() == 0) begin
        $display("%0t: unexpected result: average %0h end %0b", $time, out_tdata[16:0],
                 out_tlast);
        error_count++;
      end else begin
        want = expected_means.pop_front();
        if (out_tdata[16:0] !== want.average || out_tlast !== want.end_of_sequence) begin
          $display("%0t: mismatch: expected average %0h end %0b, actual average %0h end %0b",
                   $time, want.average, want.end_of_sequence, out_tdata[16:0], out_tlast);
          error_count++;
        end
        results_checked++;
      end
    end
  end

  // Watchdog: end the run when no transaction happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("centered_moving_average_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 29;
    recv_idle_pct = 83;
    test_default_radius();
    test_radius_extremes();
    test_radius_cuts_sequence();
    test_random_sequences(29, 83, 25);
    test_max_radius();
    test_random_sequences(83, 29, 25);
    test_output_backpressure();
    test_random_sequences(0, 0, 25);
    // Drain the remaining results, then watch for strays
    in_tvalid <= 1'b0;
    while (expected_means.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Sent %0d samples across %0d radius writes (radius 0 to 63), checked %0d results.",
             samples_sent, radius_writes, results_checked);
    $display("Included stalls on both sides, a %0d-cycle output hold-off and cut sequences.",
             HOLD_OFF_CYCLES);
    if (error_count == 0)
      $display("centered_moving_average_test OK");
    else
      $display("centered_moving_average_test NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cma_pkg.sv
rtl/cma_ram.sv
rtl/centered_moving_average.sv
rtl/cma_check.sv
bench/centered_moving_average_test.sv
